>>> rtl/table_huffman_delta_pixel_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TABLE_HUFFMAN_DELTA_PIXEL_DECODER_DEFINES_SVH
`define TABLE_HUFFMAN_DELTA_PIXEL_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Property holds in the same cycle.
`define THDPD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("thdpd check failed");
// Antecedent in this cycle implies consequent in the next.
`define THDPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thdpd check failed");
`else
`define THDPD_ASSERT(label, prop)
`define THDPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/thdpd_pkg.sv
// Shared types and constants for the table driven Huffman delta pixel decoder.
// No dependencies; imported by every module of the block.
package thdpd_pkg;

    // Table geometry
    localparam int TABLE_ROWS    = 512;
    localparam int WIDE_ROOT_ROW = 8;
    localparam int ROW_W         = 9;
    localparam int ROW_AW        = $clog2(TABLE_ROWS);
    localparam int TBL_DEPTH     = TABLE_ROWS * 2;
    localparam int TBL_AW        = $clog2(TBL_DEPTH);

    // Field widths
    localparam int DELTA_W   = 16;
    localparam int ADDR_W    = 24;
    localparam int CNT_W     = 9;
    localparam int BYTE_W    = 8;
    localparam int BIT_IDX_W = 3;
    localparam int PIXELS_MAX = 256;

    // Item modes
    localparam logic [1:0] MODE_TABLE = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ROW_W-1:0]   row_index;
        logic               entry_side;
        logic [DELTA_W-1:0] entry_delta;
        logic [ROW_W-1:0]   entry_next;
        logic               wide_pixels;
        logic [ADDR_W-1:0]  start_address;
        logic [CNT_W-1:0]   pixel_count;
        logic [BYTE_W-1:0]  code_byte;
    } in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [DELTA_W-1:0] pixel_value;
        logic               pixel_is_wide;
        logic               out_of_range;
        logic               run_done;
        logic               last;
    } out_t;

    // One table entry as stored
    typedef struct packed {
        logic [ROW_W-1:0]   next_row;
        logic [DELTA_W-1:0] delta;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BITS,
        S_FLUSH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_table;
        logic start;
        logic load_byte;
        logic step;
        logic flush;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic run_active;
        logic hit;
        logic run_end;
        logic last_bit;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

>>> rtl/thdpd_ctrl.sv
// Sequencing state machine for the decoder: accepts items, steps code bits.
// Depends on thdpd_pkg.
module thdpd_ctrl
    import thdpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] item_mode,
    output logic       item_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        stall;

    // A new pixel cannot retire the pending one while the output is held
    assign stall = status.hit && status.pend_valid && !status.out_free;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && item_mode == MODE_DATA && status.run_active)
                begin
                    state_next = S_BITS;
                end
            end
            S_BITS:
            begin
                if (!stall && ((status.hit && status.run_end) || status.last_bit))
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    case (item_mode)
                        MODE_TABLE: cmd.wr_table  = 1'b1;
                        MODE_START: cmd.start     = 1'b1;
                        MODE_DATA:  cmd.load_byte = status.run_active;
                        default:    cmd           = '0;
                    endcase
                end
            end
            S_BITS:
            begin
                cmd.step = !stall;
            end
            S_FLUSH:
            begin
                cmd.flush = status.pend_valid && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/thdpd_datapath.sv
// Datapath: code table memory, accumulator, run counters, pending and output pixel.
// Depends on thdpd_pkg and the assertion macros header.
`include "table_huffman_delta_pixel_decoder_defines.svh"

module thdpd_datapath
    import thdpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  in_t     item,
    output status_t status,
    output logic    pixel_valid,
    input  logic    pixel_ready,
    output out_t    pixel
);

    localparam logic [ROW_W-1:0] WIDE_ROOT = ROW_W'(WIDE_ROOT_ROW);
    localparam logic [ROW_W:0]   ROW_LIMIT = (ROW_W + 1)'(TABLE_ROWS);

    // Code table, two entries per row
    entry_t                tbl_mem [TBL_DEPTH];
    entry_t                rd_data_reg;
    logic                  rd_ok_reg;
    logic [ROW_W-1:0]      rd_row;
    logic                  rd_side;
    logic [TBL_AW-1:0]     rd_addr;
    logic                  wr_en;
    logic [TBL_AW-1:0]     wr_addr;

    // Run state
    logic [DELTA_W-1:0]    acc_reg, acc_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [CNT_W-1:0]      done_reg, done_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic                  wide_reg, wide_next;
    logic                  active_reg, active_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [BIT_IDX_W-1:0]  bit_reg, bit_next;
    out_t                  pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;
    out_t                  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    // Bit evaluation
    entry_t                ent;
    logic [DELTA_W-1:0]    acc_sum;
    logic                  hit;
    logic [ROW_W-1:0]      root;
    logic [ROW_W-1:0]      row_after;
    logic [ADDR_W:0]       addr_sum;
    logic [CNT_W-1:0]      done_plus;
    logic                  run_end;
    logic [BIT_IDX_W-1:0]  bit_plus;
    logic                  out_free;
    logic                  out_load;
    out_t                  new_pix;

    // Table write port
    assign wr_en   = cmd.wr_table && ({1'b0, item.row_index} < ROW_LIMIT);
    assign wr_addr = {item.row_index[ROW_AW-1:0], item.entry_side};

    // Read address: first bit on byte load, next bit on step, same bit on stall
    assign bit_plus = bit_reg + BIT_IDX_W'(1);
    always_comb
    begin
        if (cmd.load_byte)
        begin
            rd_row  = row_reg;
            rd_side = item.code_byte[0];
        end
        else if (cmd.step)
        begin
            rd_row  = row_after;
            rd_side = byte_reg[bit_plus];
        end
        else
        begin
            rd_row  = row_reg;
            rd_side = byte_reg[bit_reg];
        end
    end
    assign rd_addr = {rd_row[ROW_AW-1:0], rd_side};

    // Table memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= entry_t'({item.entry_next, item.entry_delta});
        end
        rd_data_reg <= tbl_mem[rd_addr];
        rd_ok_reg   <= ({1'b0, rd_row} < ROW_LIMIT);
    end

    // Evaluate the entry read for the current bit
    assign ent       = rd_ok_reg ? rd_data_reg : '0;
    assign acc_sum   = wide_reg ? (acc_reg + ent.delta)
                                : {8'h00, acc_reg[7:0] + ent.delta[7:0]};
    assign hit       = (ent.next_row == '0);
    assign root      = wide_reg ? WIDE_ROOT : '0;
    assign row_after = hit ? root : ent.next_row;
    assign done_plus = done_reg + CNT_W'(1);
    assign run_end   = (done_plus == total_reg);
    assign addr_sum  = {1'b0, base_reg}
                     + (wide_reg ? (ADDR_W + 1)'({done_reg, 1'b0})
                                 : (ADDR_W + 1)'(done_reg));

    always_comb
    begin
        new_pix               = '0;
        new_pix.pixel_address = addr_sum[ADDR_W-1:0];
        new_pix.pixel_value   = acc_sum;
        new_pix.pixel_is_wide = wide_reg;
        new_pix.out_of_range  = !wide_reg && addr_sum[ADDR_W];
        new_pix.run_done      = run_end;
        new_pix.last          = 1'b0;
    end

    // Output register handshake
    assign out_free = !out_valid_reg || pixel_ready;
    assign out_load = (cmd.step && hit && pend_valid_reg) || cmd.flush;

    // Next state of run and pixel registers
    always_comb
    begin
        acc_next        = acc_reg;
        row_next        = row_reg;
        base_next       = base_reg;
        done_next       = done_reg;
        total_next      = total_reg;
        wide_next       = wide_reg;
        active_next     = active_reg;
        byte_next       = byte_reg;
        bit_next        = bit_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !pixel_ready;

        if (cmd.start)
        begin
            wide_next   = item.wide_pixels;
            base_next   = item.start_address;
            total_next  = (item.pixel_count[7:0] == 8'h00) ? CNT_W'(PIXELS_MAX)
                                                           : {1'b0, item.pixel_count[7:0]};
            done_next   = '0;
            acc_next    = '0;
            row_next    = item.wide_pixels ? WIDE_ROOT : '0;
            active_next = 1'b1;
        end

        if (cmd.load_byte)
        begin
            byte_next = item.code_byte;
            bit_next  = '0;
        end

        if (out_load)
        begin
            out_next       = pend_reg;
            out_next.last  = cmd.flush;
            out_valid_next = 1'b1;
        end

        if (cmd.step)
        begin
            acc_next = acc_sum;
            row_next = row_after;
            bit_next = bit_plus;
            if (hit)
            begin
                done_next       = done_plus;
                pend_next       = new_pix;
                pend_valid_next = 1'b1;
                if (run_end)
                begin
                    active_next = 1'b0;
                end
            end
        end

        if (cmd.flush)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            row_reg        <= '0;
            base_reg       <= '0;
            done_reg       <= '0;
            total_reg      <= '0;
            wide_reg       <= 1'b0;
            active_reg     <= 1'b0;
            byte_reg       <= '0;
            bit_reg        <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            row_reg        <= row_next;
            base_reg       <= base_next;
            done_reg       <= done_next;
            total_reg      <= total_next;
            wide_reg       <= wide_next;
            active_reg     <= active_next;
            byte_reg       <= byte_next;
            bit_reg        <= bit_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Status to controller
    always_comb
    begin
        status            = '0;
        status.run_active = active_reg;
        status.hit        = hit;
        status.run_end    = run_end;
        status.last_bit   = (bit_reg == BIT_IDX_W'(BYTE_W - 1));
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

    // Checks
    `THDPD_ASSERT(a_load_only_when_free, !out_load || out_free)
    `THDPD_ASSERT(a_step_needs_run, !cmd.step || active_reg)
    `THDPD_ASSERT(a_done_below_total, !active_reg || (done_reg < total_reg))
    `THDPD_ASSERT_NEXT(a_flush_empties_pend, cmd.flush, !pend_valid_reg && out_valid_reg)

endmodule

>>> rtl/table_huffman_delta_pixel_decoder.sv
// Table driven Huffman delta pixel decoder. Table writes and start items are taken when
// idle; a data byte of an active run is accepted, then stepped one code bit per cycle
// while the pixel output does not stall (eight bits, fewer when the run ends inside
// the byte); a flush state then hands over its last pixel. The single code table read
// port sets the rate: each bit's row depends on the entry read for the previous bit.
// Each pixel is held one stage so a byte's last pixel can be marked; stalls stretch the byte.
// The code table is a 1024 x 25 bit memory with no reset; read only rows you wrote.
// Depends on thdpd_pkg, thdpd_ctrl and thdpd_datapath.
module table_huffman_delta_pixel_decoder
    import thdpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  in_t  item,
    output logic pixel_valid,
    input  logic pixel_ready,
    output out_t pixel
);

    cmd_t    cmd;
    status_t status;

    // Sequencer
    thdpd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_mode  (item.mode),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Table, accumulator and pixel output
    thdpd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item        (item),
        .status      (status),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel)
    );

endmodule

>>> bench/tb_table_huffman_delta_pixel_decoder.sv
// Self-checking bench for the table driven Huffman delta pixel decoder.
// Builds a code table, runs 8/16-bit pixel runs and checks every pixel transfer.
// Depends on thdpd_pkg and table_huffman_delta_pixel_decoder.
module tb_table_huffman_delta_pixel_decoder;
    import thdpd_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;  // unused mode, block ignores it
    localparam int STALL_LIMIT   = 3000;      // cycles with no transfer at all
    localparam int TAIL_CYCLES   = 40;
    localparam int CALM_ITEMS    = 40;        // last items sent without idling
    localparam int HOLD_AT_ITEM  = 90;
    localparam int HOLD_CYCLES   = 150;
    localparam int PLAN_ITEMS    = 228;

    typedef struct {
        in_t it;
        bit  drain;   // wait for all pending pixels before offering this item
    } plan_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    in_t  item = '0;
    logic pixel_valid;
    logic pixel_ready = 1'b0;
    out_t pixel;

    table_huffman_delta_pixel_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel)
    );

    always #1 clk = ~clk;

    // Bench-side decoder state
    logic [DELTA_W-1:0] tbl_delta [TABLE_ROWS][2];
    logic [ROW_W-1:0]   tbl_next  [TABLE_ROWS][2];
    logic [DELTA_W-1:0] acc;
    logic [ROW_W-1:0]   row_now;
    logic [ADDR_W-1:0]  base_addr;
    logic [CNT_W-1:0]   done_cnt;
    logic [CNT_W-1:0]   total_cnt;
    logic               wide_run;
    logic               run_on;

    out_t  expected_pixels [$];
    plan_t pending_items [$];

    // Generator bookkeeping: only rows with both halves written may be jumped to
    bit          side_set [TABLE_ROWS][2];
    bit          row_full [TABLE_ROWS];
    logic [ROW_W-1:0] full_rows [$];
    bit          drain_next;

    int   fail_count  = 0;
    int   total_items = 0;
    int   items_sent  = 0;
    int   idle_left   = 0;
    int   stall_left  = 0;
    int   hold_left   = 0;
    bit   hold_used   = 1'b0;
    bit   in_taken    = 1'b0;
    int   quiet_cycles = 0;
    out_t want;

    // Predict the pixels caused by one accepted item
    task automatic decode_item(input in_t it);
        out_t px;
        out_t made [$];
        logic [ROW_W-1:0]   r;
        logic [DELTA_W-1:0] d;
        logic [ROW_W-1:0]   nx;
        logic [ADDR_W:0]    full;
        case (it.mode)
            MODE_TABLE:
            begin
                if (it.row_index < TABLE_ROWS)
                begin
                    tbl_delta[it.row_index][it.entry_side] = it.entry_delta;
                    tbl_next[it.row_index][it.entry_side]  = it.entry_next;
                end
            end
            MODE_START:
            begin
                wide_run  = it.wide_pixels;
                base_addr = it.start_address;
                total_cnt = (it.pixel_count[7:0] == 8'd0) ? CNT_W'(PIXELS_MAX)
                                                          : {1'b0, it.pixel_count[7:0]};
                done_cnt  = '0;
                acc       = '0;
                row_now   = wide_run ? ROW_W'(WIDE_ROOT_ROW) : '0;
                run_on    = 1'b1;
            end
            MODE_DATA:
            begin
                for (int b = 0; b < BYTE_W && run_on; b++)
                begin
                    r  = row_now;
                    d  = '0;
                    nx = '0;
                    if (r < TABLE_ROWS)
                    begin
                        d  = tbl_delta[r][it.code_byte[b]];
                        nx = tbl_next[r][it.code_byte[b]];
                    end
                    if (wide_run)
                        acc = acc + d;
                    else
                        acc = {8'h00, acc[7:0] + d[7:0]};
                    row_now = nx;
                    if (nx == '0)
                    begin
                        px = '0;
                        if (wide_run)
                            px.pixel_address = base_addr + ADDR_W'({done_cnt, 1'b0});
                        else
                        begin
                            full = {1'b0, base_addr} + done_cnt;
                            px.pixel_address = full[ADDR_W-1:0];
                            px.out_of_range  = full[ADDR_W];
                        end
                        px.pixel_value   = acc;
                        px.pixel_is_wide = wide_run;
                        done_cnt = done_cnt + 1'b1;
                        px.run_done = (done_cnt >= total_cnt);
                        if (px.run_done)
                            run_on = 1'b0;
                        row_now = wide_run ? ROW_W'(WIDE_ROOT_ROW) : '0;
                        made.push_back(px);
                    end
                end
                if (made.size() > 0)
                    made[made.size()-1].last = 1'b1;
                foreach (made[i])
                    expected_pixels.push_back(made[i]);
            end
            default: ;
        endcase
    endtask

    // Item with every bit random; callers overwrite the fields that matter
    function automatic in_t scrambled();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(in_t)-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] pick_next();
        if ($urandom_range(0, 9) < 6)
            return '0;
        return full_rows[$urandom_range(0, full_rows.size() - 1)];
    endfunction

    task automatic queue_item(input in_t it);
        plan_t p;
        p.it       = it;
        p.drain    = drain_next;
        drain_next = 1'b0;
        pending_items.push_back(p);
    endtask

    task automatic put_entry(input int row, input bit side, input logic [DELTA_W-1:0] delta,
                             input logic [ROW_W-1:0] nxt);
        in_t it;
        it             = scrambled();
        it.mode        = MODE_TABLE;
        it.row_index   = ROW_W'(row);
        it.entry_side  = side;
        it.entry_delta = delta;
        it.entry_next  = nxt;
        side_set[row][side] = 1'b1;
        if (side_set[row][0] && side_set[row][1] && !row_full[row])
        begin
            row_full[row] = 1'b1;
            full_rows.push_back(ROW_W'(row));
        end
        queue_item(it);
    endtask

    task automatic put_start(input bit wide, input logic [ADDR_W-1:0] addr,
                             input logic [CNT_W-1:0] cnt);
        in_t it;
        it               = scrambled();
        it.mode          = MODE_START;
        it.wide_pixels   = wide;
        it.start_address = addr;
        it.pixel_count   = cnt;
        queue_item(it);
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] code);
        in_t it;
        it           = scrambled();
        it.mode      = MODE_DATA;
        it.code_byte = code;
        queue_item(it);
    endtask

    task automatic put_noise();
        in_t it;
        it      = scrambled();
        it.mode = MODE_NONE;
        queue_item(it);
    endtask

    // Stimulus plan, reset and end of test
    initial
    begin
        int row;
        drain_next = 1'b0;

        // Directed: table extremes, roots, idle data, unknown mode
        put_entry(511, 0, 16'hffff, '0);
        put_entry(511, 1, 16'h0001, '0);
        put_entry(0, 0, 16'h01ff, '0);
        put_entry(0, 1, 16'h1234, 9'd511);
        put_entry(8, 0, 16'hffff, '0);
        put_entry(8, 1, 16'h8001, 9'd511);
        put_byte(8'ha5);
        put_noise();
        // 8-bit run crossing the top of the address space, leftover bits dropped
        put_start(1'b0, 24'hfffffe, 9'd4);
        put_byte(8'h00);
        put_byte(8'hff);
        // 16-bit run with a code spanning bytes and a table write mid-run
        put_start(1'b1, 24'hfffffd, 9'h1ff);
        put_byte(8'h80);
        put_entry(511, 1, 16'h7fff, '0);
        put_byte(8'h01);
        // Start during a run, count of 256
        put_start(1'b1, 24'hfffffe, 9'h100);
        put_byte(8'hff);
        put_byte(8'h55);
        // Single pixel run; count above 256 uses its low byte
        put_start(1'b0, 24'h000000, 9'd1);
        put_byte(8'hff);
        put_start(1'b0, 24'hffffff, 9'h102);
        put_byte(8'h00);
        drain_next = 1'b1;

        // Random: mostly well formed runs, some table updates and noise
        while (pending_items.size() < PLAN_ITEMS)
        begin
            if (pending_items.size() % 70 == 0)
                drain_next = 1'b1;
            case ($urandom_range(0, 19))
                0, 1:
                begin
                    row = $urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(1, 31);
                    put_entry(row, 1'b0, 16'($urandom), pick_next());
                    put_entry(row, 1'b1, 16'($urandom), pick_next());
                end
                2:
                    put_entry($urandom_range(0, 511), 1'($urandom), 16'($urandom), pick_next());
                3:
                    put_noise();
                default:
                begin
                    put_start(1'($urandom),
                              ($urandom_range(0, 3) == 0)
                                  ? 24'(24'hffffff - $urandom_range(0, 12))
                                  : 24'($urandom),
                              ($urandom_range(0, 15) == 0) ? 9'($urandom_range(0, 511))
                                                           : 9'($urandom_range(1, 12)));
                    repeat ($urandom_range(1, 6))
                        put_byte(8'($urandom));
                end
            endcase
        end
        total_items = pending_items.size();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Drain: all items sent, all pixels in, then a quiet tail
        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Input driver: next item on the falling edge after a transfer
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || in_taken)
        begin
            if (idle_left > 0)
            begin
                item_valid <= 1'b0;
                idle_left  <= idle_left - 1;
            end
            else if (pending_items.size() == 0)
                item_valid <= 1'b0;
            else if (pending_items[0].drain && expected_pixels.size() != 0)
                item_valid <= 1'b0;
            else if (items_sent < total_items - CALM_ITEMS && $urandom_range(0, 5) == 0)
            begin
                item_valid <= 1'b0;
                idle_left  <= $urandom_range(0, 3);
            end
            else
            begin
                item       <= pending_items[0].it;
                item_valid <= 1'b1;
                pending_items.pop_front();
                items_sent <= items_sent + 1;
            end
        end
    end

    // Pixel receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            pixel_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            pixel_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end
        else if (!hold_used && items_sent >= HOLD_AT_ITEM)
        begin
            hold_used   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            pixel_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            pixel_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end
        else if (items_sent < total_items - CALM_ITEMS && $urandom_range(0, 4) == 0)
        begin
            pixel_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 3);
        end
        else
            pixel_ready <= 1'b1;
    end

    // Check pixel transfers, predict from item transfers, watchdog
    always @(posedge clk)
    begin
        in_taken <= item_valid && item_ready;
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected pixel transfer: %p", pixel);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel.pixel_address !== want.pixel_address)
                    begin
                        $error("pixel_address: expected %h, got %h",
                               want.pixel_address, pixel.pixel_address);
                        fail_count++;
                    end
                    if (pixel.pixel_value !== want.pixel_value)
                    begin
                        $error("pixel_value: expected %h, got %h",
                               want.pixel_value, pixel.pixel_value);
                        fail_count++;
                    end
                    if (pixel.pixel_is_wide !== want.pixel_is_wide)
                    begin
                        $error("pixel_is_wide: expected %b, got %b",
                               want.pixel_is_wide, pixel.pixel_is_wide);
                        fail_count++;
                    end
                    if (pixel.out_of_range !== want.out_of_range)
                    begin
                        $error("out_of_range: expected %b, got %b",
                               want.out_of_range, pixel.out_of_range);
                        fail_count++;
                    end
                    if (pixel.run_done !== want.run_done)
                    begin
                        $error("run_done: expected %b, got %b",
                               want.run_done, pixel.run_done);
                        fail_count++;
                    end
                    if (pixel.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, pixel.last);
                        fail_count++;
                    end
                end
            end
            if (item_valid && item_ready)
                decode_item(item);

            if ((item_valid && item_ready) || (pixel_valid && pixel_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/thdpd_pkg.sv
rtl/thdpd_ctrl.sv
rtl/thdpd_datapath.sv
rtl/table_huffman_delta_pixel_decoder.sv
bench/tb_table_huffman_delta_pixel_decoder.sv
